### rtl/ais_pkg.sv
package ais_pkg;

    localparam int AIS_MAX_ITEMS  = 16;
    localparam int AIS_VALUE_BITS = 32;
    localparam int AIS_FIELD_BITS = 32;

    typedef struct packed {
        logic signed [AIS_FIELD_BITS-1:0] value;
        logic                             last;
    } t_in_item;

    typedef struct packed {
        logic signed [AIS_FIELD_BITS-1:0] sorted_value;
        logic                             end_of_run;
        logic                             overflow;
    } t_out_item;

    // per-cycle command broadcast along the chain
    typedef struct packed {
        logic load;   // insert the presented value
        logic drain;  // shift toward cell 0, one result leaves
    } t_cell_ctl;

endpackage

### rtl/ascending_integer_sorter.sv
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_in_item  (value, last)
// result    out        o_out_valid / i_out_stall o_out_result (sorted_value, end_of_run, overflow)
//
// Loading takes one request per cycle; each value is inserted into the cell chain in the
// cycle it is accepted, or dropped with the overflow flag set if the chain is full. After
// the last request the chain drains from cell 0, one result per cycle, and no request is
// taken until the run is out. A stalled result holds the chain. Reset (synchronous, active low)
// clears the fill count, overflow flag and drain mode; cell contents need no reset.
module ascending_integer_sorter #(
    parameter int MAX_ITEMS  = ais_pkg::AIS_MAX_ITEMS,
    parameter int VALUE_BITS = ais_pkg::AIS_VALUE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ais_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ais_pkg::t_out_item o_out_result
);
    import ais_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_draining;
    logic          n_draining;
    logic          r_dropped;
    logic          n_dropped;

    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_full;
    logic          w_store;
    logic          w_end;
    t_cell_ctl     w_ctl;

    logic [VALUE_BITS-1:0] w_new_value;
    logic [VALUE_BITS-1:0] w_value [MAX_ITEMS];
    logic                  w_move  [MAX_ITEMS];

    assign o_in_stall  = r_draining;
    assign o_out_valid = r_draining;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign w_full      = (r_count == CW'(MAX_ITEMS));
    assign w_store     = w_in_acc && !w_full;
    assign w_end       = (r_count == CW'(1));

    assign w_ctl.load  = w_store;
    assign w_ctl.drain = w_out_acc;

    generate
        if (VALUE_BITS == AIS_FIELD_BITS) begin : g_equal
            assign w_new_value = i_in_item.value;
            assign o_out_result.sorted_value = w_value[0];
        end else if (VALUE_BITS < AIS_FIELD_BITS) begin : g_narrow
            assign w_new_value = i_in_item.value[VALUE_BITS-1:0];
            assign o_out_result.sorted_value =
                {{(AIS_FIELD_BITS - VALUE_BITS){1'b0}}, w_value[0]};
        end else begin : g_wide
            assign w_new_value = {{(VALUE_BITS - AIS_FIELD_BITS){1'b0}}, i_in_item.value};
            assign o_out_result.sorted_value = w_value[0][AIS_FIELD_BITS-1:0];
        end
    endgenerate

    assign o_out_result.end_of_run = w_end;
    assign o_out_result.overflow   = r_dropped;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            logic                  w_left_move;
            logic [VALUE_BITS-1:0] w_left_value;
            logic [VALUE_BITS-1:0] w_right_value;

            if (gi == 0) begin : g_head
                assign w_left_move  = 1'b0;
                assign w_left_value = w_new_value;
            end else begin : g_body
                assign w_left_move  = w_move[gi-1];
                assign w_left_value = w_value[gi-1];
            end

            if (gi == MAX_ITEMS - 1) begin : g_tail
                assign w_right_value = w_value[gi];
            end else begin : g_inner
                assign w_right_value = w_value[gi+1];
            end

            ais_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occupied    (r_count > CW'(gi)),
                .i_new_value   (w_new_value),
                .i_left_move   (w_left_move),
                .i_left_value  (w_left_value),
                .i_right_value (w_right_value),
                .o_move        (w_move[gi]),
                .o_value       (w_value[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count    = r_count;
        n_draining = r_draining;
        n_dropped  = r_dropped;
        if (w_store) begin
            n_count = r_count + CW'(1);
        end else if (w_out_acc) begin
            n_count = r_count - CW'(1);
        end
        if (w_in_acc && w_full) begin
            n_dropped = 1'b1;
        end
        if (w_in_acc && i_in_item.last) begin
            n_draining = 1'b1;
        end
        if (w_out_acc && w_end) begin
            n_draining = 1'b0;
            n_dropped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_draining <= 1'b0;
            r_dropped  <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_draining <= n_draining;
            r_dropped  <= n_dropped;
        end
    end

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_count != '0))
        else $error("draining with an empty chain");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_run_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_end) |=> (!r_draining && r_count == '0 && !r_dropped))
        else $error("state not cleared after the final result");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !w_end) |=> ($signed(w_value[0]) >= $signed($past(w_value[0]))))
        else $error("results out of order");

endmodule

### rtl/ais_cell.sv
module ais_cell #(
    parameter int VALUE_BITS = ais_pkg::AIS_VALUE_BITS
) (
    input  logic                  i_clk,
    input  ais_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_occupied,
    input  logic [VALUE_BITS-1:0] i_new_value,
    input  logic                  i_left_move,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic [VALUE_BITS-1:0] i_right_value,
    output logic                  o_move,
    output logic [VALUE_BITS-1:0] o_value
);
    import ais_pkg::*;

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;

    // the new value belongs at or before this cell: everything from here moves right
    assign o_move = i_ctl.load &&
                    (!i_occupied || ($signed(i_new_value) < $signed(r_value)));

    always_comb begin
        n_value = r_value;
        if (i_ctl.drain) begin
            n_value = i_right_value;
        end else if (o_move) begin
            n_value = i_left_move ? i_left_value : i_new_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
